// ----- rtl/gas_pkg.sv -----
// Package for the grabber actuator sequencer: mode codes, register indexes,
// configuration and result structs, reset values and counter width.
// No dependencies; used by every module of the block.
`default_nettype none

package gas_pkg;

  // Tick counter width (saturating)
  localparam int TICK_COUNT_BITS = 17;
  typedef logic [TICK_COUNT_BITS-1:0] tick_t;
  localparam tick_t TICK_MAX = {TICK_COUNT_BITS{1'b1}};

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THRUST_THRESHOLD  = 2'd0,
    REG_PULSE_TICKS       = 2'd1,
    REG_REPULSE_TICKS     = 2'd2,
    REG_HOLD_PERIOD_TICKS = 2'd3
  } reg_index_t;

  // Register reset values
  localparam logic [15:0] THRUST_THRESHOLD_RST  = 16'd6554;
  localparam logic [15:0] PULSE_TICKS_RST       = 16'd800;
  localparam logic [15:0] REPULSE_TICKS_RST     = 16'd500;
  localparam logic [15:0] HOLD_PERIOD_TICKS_RST = 16'd60000;

  // Sequencer modes
  typedef enum logic [2:0] {
    MODE_WAIT      = 3'd0,
    MODE_STARTUP   = 3'd1,
    MODE_READY     = 3'd2,
    MODE_ENGAGING  = 3'd3,
    MODE_LANDED    = 3'd4,
    MODE_RELEASING = 3'd5,
    MODE_REENGAGE  = 3'd6
  } mode_t;

  // Configuration bundle from register file to core
  typedef struct packed {
    logic [15:0] thrust_threshold;
    logic [15:0] pulse_ticks;
    logic [15:0] repulse_ticks;
    logic [15:0] hold_period_ticks;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [2:0] mode_code;
    logic       disengage_drive;
    logic       engage_drive;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/gas_cfg_regs.sv -----
// Configuration register file of the grabber actuator sequencer.
// Depends on gas_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module gas_cfg_regs (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [gas_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire  [15:0]                          cfg_data,
  output gas_pkg::cfg_t                        cfg
);

  // Always able to take a write transaction
  assign cfg_ready = 1'b1;

  // Decode index and write the selected register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thrust_threshold  <= gas_pkg::THRUST_THRESHOLD_RST;
      cfg.pulse_ticks       <= gas_pkg::PULSE_TICKS_RST;
      cfg.repulse_ticks     <= gas_pkg::REPULSE_TICKS_RST;
      cfg.hold_period_ticks <= gas_pkg::HOLD_PERIOD_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (gas_pkg::reg_index_t'(cfg_index))
        gas_pkg::REG_THRUST_THRESHOLD:  cfg.thrust_threshold  <= cfg_data;
        gas_pkg::REG_PULSE_TICKS:       cfg.pulse_ticks       <= cfg_data;
        gas_pkg::REG_REPULSE_TICKS:     cfg.repulse_ticks     <= cfg_data;
        gas_pkg::REG_HOLD_PERIOD_TICKS: cfg.hold_period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gas_core.sv -----
// Mode state machine, tick counter and coil levels of the sequencer.
// Depends on gas_pkg for mode_t, tick_t, cfg_t and res_t.
`default_nettype none

module gas_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 step,
  input  wire  [15:0]         thrust_level,
  input  wire                 grab_request,
  input  gas_pkg::cfg_t       cfg,
  output gas_pkg::res_t       res_next
);

  gas_pkg::mode_t mode, mode_next;
  gas_pkg::tick_t elapsed_ticks, elapsed_ticks_next, cnt_inc;
  logic           engage_level, engage_level_next;
  logic           disengage_level, disengage_level_next;

  logic ge_pulse, gt_pulse, gt_repulse, gt_hold, takeoff, release_req;

  // Saturating count-up, then the compares
  assign cnt_inc     = (elapsed_ticks == gas_pkg::TICK_MAX) ? elapsed_ticks
                     : elapsed_ticks + gas_pkg::tick_t'(1);
  assign ge_pulse    = cnt_inc >= gas_pkg::tick_t'(cfg.pulse_ticks);
  assign gt_pulse    = cnt_inc >  gas_pkg::tick_t'(cfg.pulse_ticks);
  assign gt_repulse  = cnt_inc >  gas_pkg::tick_t'(cfg.repulse_ticks);
  assign gt_hold     = cnt_inc >  gas_pkg::tick_t'(cfg.hold_period_ticks);
  assign takeoff     = thrust_level >= cfg.thrust_threshold;
  assign release_req = grab_request && (thrust_level > cfg.thrust_threshold);

  // Next mode
  always_comb begin
    mode_next = mode;
    unique case (mode)
      gas_pkg::MODE_STARTUP:   if (ge_pulse) mode_next = gas_pkg::MODE_READY;
      gas_pkg::MODE_READY:     if (grab_request) mode_next = gas_pkg::MODE_ENGAGING;
      gas_pkg::MODE_ENGAGING:  if (gt_pulse) mode_next = gas_pkg::MODE_LANDED;
      gas_pkg::MODE_LANDED: begin
        if (release_req)  mode_next = gas_pkg::MODE_RELEASING;
        else if (gt_hold) mode_next = gas_pkg::MODE_REENGAGE;
      end
      gas_pkg::MODE_RELEASING: if (gt_pulse) mode_next = gas_pkg::MODE_READY;
      gas_pkg::MODE_REENGAGE:  if (gt_repulse) mode_next = gas_pkg::MODE_LANDED;
      default: begin
        // Wait for takeoff; the unused code falls back here
        mode_next = takeoff ? gas_pkg::MODE_STARTUP : gas_pkg::MODE_WAIT;
      end
    endcase
  end

  // Counter and coil levels
  always_comb begin
    elapsed_ticks_next   = cnt_inc;
    engage_level_next    = engage_level;
    disengage_level_next = disengage_level;
    unique case (mode)
      gas_pkg::MODE_STARTUP: begin
        if (ge_pulse) disengage_level_next = 1'b0;
      end
      gas_pkg::MODE_READY: begin
        if (grab_request) begin
          engage_level_next  = 1'b1;
          elapsed_ticks_next = '0;
        end
      end
      gas_pkg::MODE_ENGAGING: begin
        if (gt_pulse) begin
          engage_level_next  = 1'b0;
          elapsed_ticks_next = '0;
        end
      end
      gas_pkg::MODE_LANDED: begin
        if (release_req) begin
          engage_level_next    = 1'b0;
          disengage_level_next = 1'b1;
          elapsed_ticks_next   = '0;
        end else if (gt_hold) begin
          engage_level_next  = 1'b1;
          elapsed_ticks_next = '0;
        end
      end
      gas_pkg::MODE_RELEASING: begin
        if (gt_pulse) disengage_level_next = 1'b0;
      end
      gas_pkg::MODE_REENGAGE: begin
        if (gt_repulse) begin
          engage_level_next  = 1'b0;
          elapsed_ticks_next = '0;
        end
      end
      default: begin
        if (takeoff) begin
          disengage_level_next = 1'b1;
          elapsed_ticks_next   = '0;
        end
      end
    endcase
  end

  // Advance state on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= gas_pkg::MODE_WAIT;
      elapsed_ticks   <= '0;
      engage_level    <= 1'b0;
      disengage_level <= 1'b0;
    end else if (step) begin
      mode            <= mode_next;
      elapsed_ticks   <= elapsed_ticks_next;
      engage_level    <= engage_level_next;
      disengage_level <= disengage_level_next;
    end
  end

  assign res_next.engage_drive    = engage_level_next;
  assign res_next.disengage_drive = disengage_level_next;
  assign res_next.mode_code       = mode_next;

endmodule

`default_nettype wire

// ----- rtl/grabber_actuator_sequencer.sv -----
// Grabber actuator sequencer top level: input register, core, result register.
// An input transaction is captured in the input register; its result is loaded
// into the result register when free or draining. Throughput: one item per cycle
// while m_tready does not stall; the single mode/counter update sets it.
// Reset (rst, synchronous): mode wait-takeoff, counter and coils cleared,
// registers at their defaults, both pipeline registers empty.
`default_nettype none

module grabber_actuator_sequencer (
  input  wire         clk,
  input  wire         rst,
  // Input stream: tdata = thrust_level[15:0], grab_request[16], zero pad [23:17]
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,
  // Result stream: tdata = engage_drive[0], disengage_drive[1], mode_code[4:2],
  // zero pad [7:5]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,
  // Configuration write channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [gas_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [15:0] cfg_data
);

  gas_pkg::cfg_t cfg;
  gas_pkg::res_t res_next;

  logic        in_valid;
  logic [15:0] in_thrust;
  logic        in_req;
  logic        step;

  gas_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Process the held item when the result register is free or draining
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_thrust <= s_tdata[15:0];
      in_req    <= s_tdata[16];
    end
  end

  gas_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .thrust_level (in_thrust),
    .grab_request (in_req),
    .cfg          (cfg),
    .res_next     (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {3'b000, res_next};
    end
  end

endmodule

`default_nettype wire
